### hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

   localparam int unsigned COLUMNS_DEFAULT = 80;
   localparam int unsigned ROWS_DEFAULT    = 25;

   localparam logic       ACT_WRITE = 1'b0;
   localparam logic       ACT_READ  = 1'b1;

   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_LINE_FEED = 8'd10;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] RESET_ATTR     = 8'h07;

   typedef struct packed {
      logic        action;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [10:0] cursor_position;
      logic        scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL_MOVE,
      ST_SCROLL_FILL,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

### hdl/text_console_writer.sv
// Text console writer: screen store, cursor, scroll sequencer and result register.
// A character cell console of COLUMNS x ROWS 16-bit cells (attribute high byte, character low
// byte) held in one synchronous memory with one write and one read port. After reset the
// block runs a clearing pass over every cell, filling each with 0x0720, and takes
// no word meanwhile; csr writes are taken at all times. A character write that does not scroll
// is stored at once, a cell read goes through the registered memory read. A write that runs past
// the last cell scrolls the store through the single write port: it moves each cell up one row,
// drains the last pending move, blanks the bottom row in the current attribute and then posts the
// result. Results leave through an output register, so the next word is accepted while a result
// still waits to be taken.
`default_nettype none
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = ROWS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   localparam int unsigned CELLS  = COLUMNS * ROWS;
   localparam int unsigned ADDR_W = $clog2(CELLS);
   localparam int unsigned COL_W  = $clog2(COLUMNS);
   localparam int unsigned ROW_W  = $clog2(ROWS);
   localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP     = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);

   logic [15:0] mem [CELLS];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [7:0]        attr_ff;
   logic              mv_valid_ff, mv_valid_in;
   logic [ADDR_W-1:0] mv_addr_ff, mv_addr_in;
   logic              rd_range_ff, rd_range_in;
   logic [15:0]       rd_data_ff;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept, rsp_free, is_cr, is_lf, is_plain, write_scroll;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]       wr_data;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_cr     = (req_data.char_code == CHAR_RETURN);
   assign is_lf     = (req_data.char_code == CHAR_LINE_FEED);
   assign is_plain  = !is_cr && !is_lf;
   assign write_scroll = (row_ff == LAST_ROW) && (is_lf || (is_plain && col_ff == LAST_COL));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               priority if (req_data.action == ACT_READ) state_in = ST_READ;
               else if (write_scroll)                    state_in = ST_SCROLL_MOVE;
               else if (!rsp_free)                       state_in = ST_EMIT;
               else                                      state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = rsp_free ? ST_IDLE : ST_EMIT;
         end
         ST_SCROLL_MOVE: begin
            if (scan_ff == LAST_CELL) state_in = ST_SCROLL_FILL;
         end
         ST_SCROLL_FILL: begin
            if (!mv_valid_ff && scan_ff == LAST_CELL) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rd_addr   = scan_ff;
      wr_en     = 1'b0;
      wr_addr   = scan_ff;
      wr_data   = {attr_ff, CHAR_SPACE};
      priority if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_data = {RESET_ATTR, CHAR_SPACE};
      end else if (mv_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = mv_addr_ff;
         wr_data = rd_data_ff;
      end else if (state_ff == ST_SCROLL_FILL) begin
         wr_en   = 1'b1;
      end else if (accept && req_data.action == ACT_WRITE && is_plain) begin
         wr_en   = 1'b1;
         wr_addr = cursor_ff;
         wr_data = {attr_ff, req_data.char_code};
      end else begin
         wr_en   = 1'b0;
      end
      if (state_ff == ST_IDLE) rd_addr = ADDR_W'(req_data.cell_index);
   end

   always_comb begin
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      scan_in      = scan_ff;
      mv_valid_in  = 1'b0;
      mv_addr_in   = mv_addr_ff;
      rd_range_in  = rd_range_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            scan_in = (scan_ff == LAST_CELL) ? '0 : scan_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_READ) begin
                  rd_range_in            = (32'(req_data.cell_index) < 32'(CELLS));
                  res_in.cell_value      = '0;
                  res_in.cursor_position = 11'(cursor_ff);
                  res_in.scrolled        = 1'b0;
               end else begin
                  priority if (write_scroll) begin
                     cursor_in = BOTTOM_START;
                     col_in    = '0;
                     row_in    = LAST_ROW;
                     scan_in   = ROW_STEP;
                  end else if (is_cr) begin
                     cursor_in = cursor_ff - ADDR_W'(col_ff);
                     col_in    = '0;
                  end else if (is_lf) begin
                     cursor_in = cursor_ff + ROW_STEP - ADDR_W'(col_ff);
                     col_in    = '0;
                     row_in    = row_ff + 1'b1;
                  end else if (col_ff == LAST_COL) begin
                     cursor_in = cursor_ff + 1'b1;
                     col_in    = '0;
                     row_in    = row_ff + 1'b1;
                  end else begin
                     cursor_in = cursor_ff + 1'b1;
                     col_in    = col_ff + 1'b1;
                  end
                  res_in.cell_value      = '0;
                  res_in.cursor_position = 11'(cursor_in);
                  res_in.scrolled        = write_scroll;
                  if (!write_scroll && rsp_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = res_in;
                  end
               end
            end
         end
         ST_READ: begin
            res_in.cell_value = rd_range_ff ? rd_data_ff : 16'h0000;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_in;
            end
         end
         ST_SCROLL_MOVE: begin
            mv_valid_in = 1'b1;
            mv_addr_in  = scan_ff - ROW_STEP;
            scan_in     = (scan_ff == LAST_CELL) ? BOTTOM_START : scan_ff + 1'b1;
         end
         ST_SCROLL_FILL: begin
            if (!mv_valid_ff) scan_in = (scan_ff == LAST_CELL) ? '0 : scan_ff + 1'b1;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         scan_ff      <= '0;
         attr_ff      <= RESET_ATTR;
         mv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scan_ff      <= scan_in;
         mv_valid_ff  <= mv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      mv_addr_ff  <= mv_addr_in;
      rd_range_ff <= rd_range_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < 32'(CELLS))
      else $error("cursor beyond screen store");

   a_cursor_matches_row_col: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff))
      else $error("cursor out of step with row and column");

   a_scroll_cursor_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.scrolled |-> 32'(rsp_data_ff.cursor_position) == CELLS - COLUMNS)
      else $error("scroll result with cursor off the bottom row start");

   a_move_only_in_scroll: assert property (@(posedge clock) disable iff (reset)
      mv_valid_ff |-> state_ff == ST_SCROLL_MOVE || state_ff == ST_SCROLL_FILL)
      else $error("pending cell move outside a scroll");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCROLL_MOVE || state_ff == ST_CLEAR |-> !req_ready)
      else $error("word accepted during a store sweep");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
// Testbench for the text console writer: shadow screen scoreboard, word stimulus and checks.
`timescale 1ns / 100ps

import tcw_pkg::*;

localparam int unsigned COLS  = COLUMNS_DEFAULT;
localparam int unsigned CELLS = COLUMNS_DEFAULT * ROWS_DEFAULT;

class console_scoreboard;
   logic [15:0] screen [CELLS];
   int unsigned cursor;
   logic [7:0]  attribute;
   rsp_type     due_results[$];
   int unsigned errors;

   function new();
      attribute = RESET_ATTR;
      foreach (screen[i]) begin
         screen[i] = {RESET_ATTR, CHAR_SPACE};
      end
      cursor  = 0;
      errors  = 0;
   endfunction

   function void set_attribute(logic [7:0] value);
      attribute = value;
   endfunction

   function int unsigned waiting();
      return due_results.size();
   endfunction

   function void scroll_screen();
      for (int unsigned i = 0; i < CELLS - COLS; i++) begin
         screen[i] = screen[i + COLS];
      end
      for (int unsigned i = CELLS - COLS; i < CELLS; i++) begin
         screen[i] = {attribute, CHAR_SPACE};
      end
      cursor = CELLS - COLS;
   endfunction

   function void note_word(req_type w);
      rsp_type r;
      r = '0;
      if (w.action == ACT_READ) begin
         if (w.cell_index < CELLS) begin
            r.cell_value = screen[w.cell_index];
         end
      end else begin
         if (w.char_code == CHAR_RETURN) begin
            cursor = cursor - cursor % COLS;
         end else if (w.char_code == CHAR_LINE_FEED) begin
            cursor = cursor + COLS - cursor % COLS;
         end else begin
            screen[cursor] = {attribute, w.char_code};
            cursor = cursor + 1;
         end
         if (cursor >= CELLS) begin
            scroll_screen();
            r.scrolled = 1'b1;
         end
      end
      r.cursor_position = cursor[10:0];
      due_results.push_back(r);
   endfunction

   function void flag(string field, int unsigned expected, int unsigned actual);
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, field, expected, actual);
   endfunction

   function void check_result(rsp_type got);
      rsp_type exp;
      if (due_results.size() == 0) begin
         flag("unexpected word, raw", 0, 32'(got));
         return;
      end
      exp = due_results.pop_front();
      if (got.cell_value !== exp.cell_value) begin
         flag("cell_value", 32'(exp.cell_value), 32'(got.cell_value));
      end
      if (got.cursor_position !== exp.cursor_position) begin
         flag("cursor_position", 32'(exp.cursor_position), 32'(got.cursor_position));
      end
      if (got.scrolled !== exp.scrolled) begin
         flag("scrolled", 32'(exp.scrolled), 32'(got.scrolled));
      end
   endfunction
endclass

module tb_top;
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   console_scoreboard board = new();

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned results_seen = 0;
   int unsigned hold_left = 0;
   int unsigned next_hold_at = 400;

   text_console_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #150ms;
      $display("tb_top: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
            results_seen <= results_seen + 1;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (results_seen == next_hold_at) begin
            // hold off long enough for the block to fill and stall its input
            rsp_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 700;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      board.note_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.waiting() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_attribute(input logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_attribute(value);
   endtask

   task automatic send_op(input logic act, input logic [7:0] code, input logic [10:0] idx);
      req_type w;
      w.action     = act;
      w.char_code  = code;
      w.cell_index = idx;
      send_word(w);
   endtask

   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      w.char_code  = 8'($urandom_range(255));
      w.cell_index = 11'($urandom_range(2047));
      pick         = $urandom_range(99);
      if (pick < 38) begin
         w.action = ACT_READ;
         if ($urandom_range(9) != 0) begin
            w.cell_index = 11'($urandom_range(CELLS - 1));
         end
      end else begin
         w.action = ACT_WRITE;
         if (pick < 41) begin
            w.char_code = CHAR_RETURN;
         end else if (pick < 44) begin
            w.char_code = CHAR_LINE_FEED;
         end
      end
      return w;
   endfunction

   task automatic run_phase(input logic [7:0] attr, input int unsigned gap,
                            input int unsigned stall, input int unsigned count);
      int unsigned sent;
      int unsigned burst;
      write_attribute(attr);
      gap_pct   = gap;
      stall_pct = stall;
      sent      = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 3) begin
            // run of line feeds to reach the bottom row and scroll
            burst = $urandom_range(30, 8);
            repeat (burst) begin
               send_op(ACT_WRITE, CHAR_LINE_FEED, 11'($urandom_range(2047)));
            end
            sent += burst;
         end else begin
            send_word(random_word());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      gap_pct   = 12;
      stall_pct = 55;

      send_op(ACT_READ, 8'h00, 11'd0);
      send_op(ACT_READ, 8'hFF, 11'd1999);
      send_op(ACT_READ, 8'h00, 11'd2000);
      send_op(ACT_READ, 8'hFF, 11'd2047);
      send_op(ACT_WRITE, 8'h00, 11'd0);
      send_op(ACT_WRITE, 8'hFF, 11'd2047);
      send_op(ACT_WRITE, 8'h41, 11'd0);
      send_op(ACT_WRITE, CHAR_RETURN, 11'd0);
      send_op(ACT_WRITE, 8'h42, 11'd0);
      send_op(ACT_WRITE, CHAR_LINE_FEED, 11'd0);
      send_op(ACT_WRITE, CHAR_RETURN, 11'd0);
      send_op(ACT_WRITE, 8'h7F, 11'd0);
      send_op(ACT_WRITE, CHAR_LINE_FEED, 11'd0);
      send_op(ACT_WRITE, CHAR_LINE_FEED, 11'd0);
      send_op(ACT_READ, 8'h00, 11'd0);
      send_op(ACT_READ, 8'h00, 11'd1);
      send_op(ACT_READ, 8'h00, 11'd2);
      send_op(ACT_READ, 8'h00, 11'd80);
      send_op(ACT_READ, 8'h00, 11'd160);
      send_op(ACT_WRITE, 8'h80, 11'd0);
      send_op(ACT_READ, 8'h00, 11'd240);

      run_phase(8'h00, 12, 55, 272);
      run_phase(8'hFF, 12, 55, 272);
      run_phase(8'($urandom_range(255)), 55, 12, 272);
      run_phase(8'($urandom_range(255)), 55, 12, 272);
      run_phase(RESET_ATTR, 0, 0, 272);
      run_phase(8'($urandom_range(255)), 0, 0, 272);

      drain();
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
